FILE: src/singular_pair_quadrature_generator_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef SINGULAR_PAIR_QUADRATURE_GENERATOR_UNIT_MACROS_SVH
`define SINGULAR_PAIR_QUADRATURE_GENERATOR_UNIT_MACROS_SVH

// Checked at every edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

// Checked outside reset only.
`define SPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

FILE: src/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Types, constants and helper functions of the singular pair quadrature unit.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int GRID_POINTS_PER_AXIS = 8;

    typedef logic [30:0]        t_uq;   // unsigned Q.30, values up to 1.0
    typedef logic signed [34:0] t_sq;   // signed Q.30 working value
    typedef logic [17:0]        t_q116;

    typedef enum logic [1:0] {
        MODE_VERTEX = 2'd0,
        MODE_EDGE   = 2'd1,
        MODE_FACET  = 2'd2
    } t_mode;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_PERM_A = 2'd1;
    localparam logic [1:0] CFG_PERM_B = 2'd2;

    localparam logic [2:0] PERM_MAX = 3'd5;
    localparam logic [2:0] MODE_MAX = 3'd2;

    localparam t_sq QONE = t_sq'(35'sd1 <<< 30);

    localparam logic [3:0] LAST_STEP = 4'd8;
    localparam logic [3:0] PUSH_STEP = 4'd9;

    // destination component of each coordinate, per permutation code
    localparam logic [1:0] PERM [6][3] = '{
        '{2'd0, 2'd1, 2'd2}, '{2'd2, 2'd0, 2'd1}, '{2'd1, 2'd2, 2'd0},
        '{2'd0, 2'd2, 2'd1}, '{2'd2, 2'd1, 2'd0}, '{2'd1, 2'd0, 2'd2}
    };

    typedef struct packed {
        logic [3:0][15:0] wgt;
        logic [3:0][15:0] node;
    } t_in;

    // per item products handed from front to back
    typedef struct packed {
        t_uq q;
        t_uq v0;
        t_uq v1;
        t_uq v2;
        t_uq pw;
    } t_job;

    typedef t_sq t_trip [3];

    function automatic t_trip place(input logic [2:0] code, input t_sq c0,
                                    input t_sq c1, input t_sq c2);
        t_trip r;
        logic [2:0] cd;
        cd = (code > PERM_MAX) ? 3'd0 : code;
        r[PERM[cd][0]] = c0;
        r[PERM[cd][1]] = c1;
        r[PERM[cd][2]] = c2;
        return r;
    endfunction

    // Q.30 to Q1.16, round half away from zero, saturate
    function automatic t_q116 to_q116(input t_sq v);
        logic [34:0] mag;
        logic [21:0] m;
        mag = v[34] ? 35'(-v) : 35'(v);
        m = 22'((36'(mag) + 36'd8192) >> 14);
        if (v[34]) begin
            return (m > 22'd131072) ? 18'h20000 : 18'(22'd0 - m);
        end
        return (m > 22'd131071) ? 18'h1FFFF : m[17:0];
    endfunction

endpackage

FILE: src/spq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_front
// Takes grid point items and works out their products on one shared
// rounding multiplier, one product per cycle, then queues the job.
// ----------------------------------------------------------------------------
module spq_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_mode,
    input  logic            i_in_vld,
    output logic            o_in_rdy,
    input  spq_pkg::t_in    i_in,
    output logic            o_push,
    input  logic            i_full,
    output spq_pkg::t_job   o_job
);

    logic          r_hold_vld;
    spq_pkg::t_in  r_hold;
    logic          r_busy;
    logic [3:0]    r_step;
    spq_pkg::t_in  r_cur;
    spq_pkg::t_uq  r_w, r_v0, r_v1, r_v2, r_v3, r_pw;

    spq_pkg::t_uq  op_a, op_b, q, om1, prod_r;
    spq_pkg::t_uq  nd [4];
    spq_pkg::t_uq  wt [4];
    logic [61:0]   prod;
    logic          load;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            nd[i] = {1'b0, r_cur.node[i], 14'd0};
            wt[i] = {1'b0, r_cur.wgt[i], 14'd0};
        end
    end

    assign q   = nd[0];
    assign om1 = 31'(32'd1 << 30) - q;

    assign o_push = r_busy && (r_step == spq_pkg::PUSH_STEP) && !i_full;
    assign load   = r_hold_vld && (!r_busy || o_push);
    assign o_in_rdy = !r_hold_vld || load;
    assign o_job  = '{q: q, v0: r_v0, v1: r_v1, v2: r_v2, pw: r_pw};

    // operand schedule; every step of every mode multiplies values in [0,1]
    always_comb begin
        op_a = r_w;
        op_b = wt[1];
        case (r_step)
            4'd0: begin op_a = wt[0]; op_b = wt[1]; end
            4'd1: begin op_a = r_w;   op_b = wt[2]; end
            4'd2: begin op_a = r_w;   op_b = wt[3]; end
            4'd3: begin op_a = q;     op_b = nd[1]; end
            4'd4: begin
                op_b = nd[2];
                op_a = (i_mode == spq_pkg::MODE_EDGE)  ? r_v0 :
                       (i_mode == spq_pkg::MODE_FACET) ? om1 : q;
            end
            4'd5: begin
                op_b = nd[3];
                op_a = (i_mode == spq_pkg::MODE_EDGE) ? om1 : r_v1;
            end
            4'd6: begin
                op_a = (i_mode == spq_pkg::MODE_EDGE)  ? r_v0 :
                       (i_mode == spq_pkg::MODE_FACET) ? om1 : r_v1;
                op_b = q;
            end
            4'd7: begin
                op_a = r_v3;
                op_b = (i_mode == spq_pkg::MODE_EDGE)  ? om1 :
                       (i_mode == spq_pkg::MODE_FACET) ? r_v1 : q;
            end
            default: begin op_a = r_w; op_b = r_v3; end
        endcase
    end

    assign prod   = 62'(op_a) * 62'(op_b);
    assign prod_r = 31'((prod + 62'(32'd1 << 29)) >> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_busy     <= 1'b0;
            r_step     <= 4'd0;
        end else begin
            if (i_in_vld && o_in_rdy) begin
                r_hold_vld <= 1'b1;
            end else if (load) begin
                r_hold_vld <= 1'b0;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_step <= 4'd0;
            end else if (o_push) begin
                r_busy <= 1'b0;
            end else if (r_busy && r_step != spq_pkg::PUSH_STEP) begin
                r_step <= r_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_vld && o_in_rdy) r_hold <= i_in;
        if (load) r_cur <= r_hold;
        if (r_busy) begin
            case (r_step)
                4'd0, 4'd1, 4'd2: r_w <= prod_r;
                4'd3: r_v0 <= prod_r;
                4'd4: r_v1 <= prod_r;
                4'd5: r_v2 <= prod_r;
                4'd6, 4'd7: r_v3 <= prod_r;
                spq_pkg::LAST_STEP: r_pw <= prod_r;
                default: ;
            endcase
        end
    end

endmodule

FILE: src/spq_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_fifo
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module spq_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  spq_pkg::t_job   i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output spq_pkg::t_job   o_job
);

    spq_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

endmodule

FILE: src/spq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_back
// Expands one queued job into its run of paired points, one result a cycle
// unless the output is stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module spq_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_mode,
    input  logic [2:0]      i_perm_a,
    input  logic [2:0]      i_perm_b,
    input  logic            i_empty,
    input  spq_pkg::t_job   i_job,
    output logic            o_pop,
    output logic            o_vld,
    input  logic            i_rdy,
    output logic [143:0]    o_data,
    output logic            o_last
);

    logic [3:0]   r_k;
    logic         r_vld;
    logic [143:0] r_data;
    logic         r_last;

    logic [3:0]   run, base, bidx;
    logic         swap, adv, is_last;
    spq_pkg::t_sq q, v0, v1, v2;
    spq_pkg::t_sq x1, x2, e1, e2, s1, s2, t1, t2;
    spq_pkg::t_trip fa, fb;
    logic [2:0]   pa, pb;
    logic [32:0]  w33;
    logic [31:0]  wsat;

    assign q  = 35'(i_job.q);
    assign v0 = 35'(i_job.v0);
    assign v1 = 35'(i_job.v1);
    assign v2 = 35'(i_job.v2);

    always_comb begin
        unique case (i_mode)
            spq_pkg::MODE_EDGE:  run = 4'd12;
            spq_pkg::MODE_FACET: run = 4'd6;
            default:             run = 4'd2;
        endcase
        base = run >> 1;
        swap = (r_k >= base);
        bidx = swap ? r_k - base : r_k;
    end

    // base case coordinates from the queued products
    always_comb begin
        x1 = q; x2 = v0; e1 = v1; e2 = v2;
        if (i_mode == spq_pkg::MODE_EDGE) begin
            // v0 = A, v1 = B, v2 = bs
            case (bidx)
                4'd0: begin x1 = v2 + q;      x2 = q - v0 + v1;
                            e1 = v2 + q - v0; e2 = q - v0; end
                4'd1: begin x1 = v2 + q - v0; x2 = q - v0;
                            e1 = v2 + q;      e2 = q - v0 + v1; end
                4'd2: begin x1 = v2 + q;      x2 = q - v0;
                            e1 = v2 + q - v1; e2 = q - v1; end
                4'd3: begin x1 = v2 + q - v1; x2 = q - v1;
                            e1 = v2 + q;      e2 = q - v0; end
                4'd4: begin x1 = v2 + q;      x2 = q;
                            e1 = v2 + q - v1; e2 = q - v0; end
                default: begin x1 = v2 + q - v1; x2 = q - v0;
                            e1 = v2 + q;      e2 = q; end
            endcase
        end else if (i_mode == spq_pkg::MODE_FACET) begin
            // v0 = q*n1, v1 = (1-q)*n2, v2 = v1*n3
            case (bidx)
                4'd0: begin x1 = v1; x2 = v2; e1 = q + v1; e2 = v0 + v2; end
                4'd1: begin x1 = v1 - v0 + q; x2 = v2 - v0 + q;
                            e1 = v1 + q;      e2 = v2; end
                default: begin x1 = v1 + q - v0; x2 = v2;
                            e1 = v1 + q;      e2 = q + v2; end
            endcase
        end
        s1 = swap ? e1 : x1;
        s2 = swap ? e2 : x2;
        t1 = swap ? x1 : e1;
        t2 = swap ? x2 : e2;
    end

    assign pa = (i_mode == spq_pkg::MODE_FACET) ? 3'd0 : i_perm_a;
    assign pb = (i_mode == spq_pkg::MODE_FACET) ? 3'd0 : i_perm_b;
    assign fa = spq_pkg::place(pa, spq_pkg::QONE - s1, s1 - s2, s2);
    assign fb = spq_pkg::place(pb, spq_pkg::QONE - t1, t1 - t2, t2);

    // edge runs carry half the weight
    assign w33  = (i_mode == spq_pkg::MODE_EDGE) ? {1'b0, i_job.pw, 1'b0}
                                                 : {i_job.pw, 2'b00};
    assign wsat = w33[32] ? 32'hFFFF_FFFF : w33[31:0];

    assign is_last = (r_k == run - 4'd1);
    assign adv     = !i_empty && (!r_vld || i_rdy);
    assign o_pop   = adv && is_last;
    assign o_vld   = r_vld;
    assign o_data  = r_data;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= 4'd0;
            r_vld <= 1'b0;
        end else begin
            if (adv) begin
                r_vld <= 1'b1;
                r_k   <= is_last ? 4'd0 : r_k + 4'd1;
            end else if (i_rdy) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_data <= {r_k, wsat,
                       spq_pkg::to_q116(fb[2]), spq_pkg::to_q116(fb[1]),
                       spq_pkg::to_q116(fb[0]),
                       spq_pkg::to_q116(fa[2]), spq_pkg::to_q116(fa[1]),
                       spq_pkg::to_q116(fa[0])};
            r_last <= is_last;
        end
    end

endmodule

FILE: src/singular_pair_quadrature_generator_unit.sv
`timescale 1ns / 1ps
// Front: each item takes nine products on one multiplier plus the queue write.
// Back: each item expands into 2, 12 or 6 results (vertex, edge, facet mode),
// one result a cycle unless the output is stalled; the slower of the two parts
// sets the rate. Reset (synchronous, active low) clears the registers to
// mode 0, codes 0, and empties all stages.
// ----------------------------------------------------------------------------
// singular_pair_quadrature_generator_unit
// Top level: config registers, front product sequencer, job queue, expander.
// ----------------------------------------------------------------------------
module singular_pair_quadrature_generator_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [1:0]    i_cfg_index,
    input  logic [2:0]    i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // node_one, node_two, node_three, node_four,
    // weight_one, weight_two, weight_three, weight_four (16 bits each)
    input  logic [127:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // first_bary_a/b/c, second_bary_a/b/c (18 each), pair_weight (32),
    // case_index (4)
    output logic [143:0]  m_axis_tdata,
    output logic          m_axis_tlast
);

    logic [1:0] r_mode;
    logic [2:0] r_perm_a, r_perm_b;

    logic          push, pop, full, empty;
    spq_pkg::t_job f_job, q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 2'd0;
            r_perm_a <= 3'd0;
            r_perm_b <= 3'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                spq_pkg::CFG_MODE:
                    if (i_cfg_data <= spq_pkg::MODE_MAX) r_mode <= i_cfg_data[1:0];
                spq_pkg::CFG_PERM_A:
                    if (i_cfg_data <= spq_pkg::PERM_MAX) r_perm_a <= i_cfg_data;
                spq_pkg::CFG_PERM_B:
                    if (i_cfg_data <= spq_pkg::PERM_MAX) r_perm_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    spq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (r_mode),
        .i_in_vld (s_axis_tvalid),
        .o_in_rdy (s_axis_tready),
        .i_in     (spq_pkg::t_in'(s_axis_tdata)),
        .o_push   (push),
        .i_full   (full),
        .o_job    (f_job)
    );

    spq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (q_job)
    );

    spq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (r_mode),
        .i_perm_a (r_perm_a),
        .i_perm_b (r_perm_b),
        .i_empty  (empty),
        .i_job    (q_job),
        .o_pop    (pop),
        .o_vld    (m_axis_tvalid),
        .i_rdy    (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule

FILE: src/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_props
// Port level checks on the result stream of the quadrature unit.
// ----------------------------------------------------------------------------
`include "singular_pair_quadrature_generator_unit_macros.svh"

module spq_props (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata,
    input logic         m_axis_tlast
);

    `SPQ_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled item changed")
    `SPQ_ASSERT(a_index, m_axis_tvalid |-> m_axis_tdata[143:140] <= 4'd11, "case index out of range")
    // every run has even length, so its last case index is odd
    `SPQ_ASSERT(a_last_odd, m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[140], "run ends on even index")
    `SPQ_ASSERT_ALWAYS(a_rst, !i_rst_n |=> !m_axis_tvalid, "valid after reset")

endmodule

bind singular_pair_quadrature_generator_unit spq_props u_spq_props (.*);
